/* rtl/brb_pkg.sv */
// Package for the byte ring buffer: field widths, command codes, transaction types, FSM states.
package brb_pkg;

   localparam int DEPTH_DEF   = 4096;
   localparam int MAX_RUN_DEF = 64;

   localparam int CAP_W   = 13;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_ADVANCE = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type             command;
      logic [BYTE_W-1:0]   data_in;
      logic [COUNT_W-1:0]  count;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_out;
      logic                has_data;
      logic [COUNT_W-1:0]  granted;
      logic                last;
      logic [CAP_W-1:0]    fill_level;
      logic [CAP_W-1:0]    free_space;
   } rsp_type;

endpackage

/* rtl/brb_ram.sv */
// Byte store: single write port, one registered read port.
module brb_ram #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [brb_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [brb_pkg::BYTE_W-1:0] rd_data
);

   logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [brb_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/byte_ring_buffer.sv */
// Byte ring buffer top level: command decode, pointer/fill control and result register.
//
// Circular byte FIFO of DEPTH slots, of which csr_wr_data selects how many are used
// (values below 1 act as 1, above DEPTH as DEPTH); writing the capacity also empties
// the buffer. Each req transaction carries one command. A write stores data_in when
// the buffer is not full and yields one rsp transaction (granted 1, or 0 when the byte
// was dropped). Read and peek hand out min(count, MAX_RUN, fill) bytes, one rsp
// transaction per byte with last on the final one; read consumes them, peek leaves
// them. An advance discards up to count bytes and yields one rsp transaction. A read
// or peek that grants nothing yields one rsp transaction with has_data low. Every
// rsp transaction reports fill_level and free_space after its command.
// Timing: write, advance and empty read/peek finish without a run, so writes stream at
// one per cycle while rsp_ready stays high. A read or peek that grants bytes starts a
// run: the byte RAM read is registered, then bytes leave at one per cycle while
// rsp_ready stays high; no req transaction is taken during the run. The byte
// store needs no clearing after reset: only written entries are ever read.
module byte_ring_buffer #(
   parameter int DEPTH   = brb_pkg::DEPTH_DEF,
   parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  brb_pkg::req_type           req_data,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output brb_pkg::rsp_type           rsp_data,
   // capacity register
   input  logic                       csr_wr_en,
   input  logic [brb_pkg::CAP_W-1:0]  csr_wr_data
);

   localparam int PW = $clog2(DEPTH);        // pointer width
   localparam int CW = $clog2(DEPTH + 1);    // fill / capacity width
   localparam int SW = CW + 1;               // pointer + run sum width
   localparam int RW = $clog2(MAX_RUN + 1);  // run length width
   localparam int WW = (CW > brb_pkg::COUNT_W) ? CW : brb_pkg::COUNT_W;
   localparam logic [brb_pkg::COUNT_W-1:0] MAX_RUN_C = brb_pkg::COUNT_W'(MAX_RUN);

   // control state
   brb_pkg::state_type state_ff, state_in;
   logic [PW-1:0]      wp_ff, wp_in;
   logic [PW-1:0]      rp_ff, rp_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      cap_ff, cap_in;

   // run sequencer
   logic [PW-1:0]      run_rp_ff, run_rp_in;
   logic [RW-1:0]      issue_left_ff, issue_left_in;
   logic [RW-1:0]      emit_idx_ff, emit_idx_in;
   logic [RW-1:0]      run_n_ff, run_n_in;
   logic               rd_pending_ff, rd_pending_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   brb_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // RAM hookup
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [brb_pkg::BYTE_W-1:0] ram_rd_data;

   // decode helpers
   logic                       accept;
   logic                       out_free;
   logic                       full;
   logic [brb_pkg::COUNT_W-1:0] req_clamped;
   logic [WW-1:0]              grant_w;
   logic [CW-1:0]              grant;
   logic [SW-1:0]              adv_sum;
   logic [PW-1:0]              rp_adv;
   logic [PW-1:0]              wp_bump;
   logic [PW-1:0]              run_rp_bump;
   logic                       move;
   logic [CW-1:0]              cap_wr;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == brb_pkg::ST_IDLE) && out_free;
   assign accept = req_valid && req_ready;
   assign full = (fill_ff >= cap_ff);

   // granted length: min(count, MAX_RUN, fill)
   assign req_clamped = (req_data.count > MAX_RUN_C) ? MAX_RUN_C : req_data.count;
   assign grant_w = (WW'(req_clamped) > WW'(fill_ff)) ? WW'(fill_ff) : WW'(req_clamped);
   assign grant = CW'(grant_w);

   // read pointer after skipping grant bytes: rp < cap and grant <= cap, one wrap at most
   assign adv_sum = SW'(rp_ff) + SW'(grant);
   assign rp_adv = (adv_sum >= SW'(cap_ff)) ? PW'(adv_sum - SW'(cap_ff)) : PW'(adv_sum);

   assign wp_bump = (SW'(wp_ff) + SW'(1) >= SW'(cap_ff)) ? '0 : wp_ff + PW'(1);
   assign run_rp_bump = (SW'(run_rp_ff) + SW'(1) >= SW'(cap_ff)) ? '0 : run_rp_ff + PW'(1);

   // clamp of a capacity write
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_wr = CW'(1);
      end else if (32'(csr_wr_data) > DEPTH) begin
         cap_wr = CW'(DEPTH);
      end else begin
         cap_wr = CW'(csr_wr_data);
      end
   end

   // run: move a fetched byte into the result register when it is free
   assign move = (state_ff == brb_pkg::ST_RUN) && rd_pending_ff && out_free;
   // fetch the next byte when the fetch register is empty or emptying now
   assign ram_rd_en = (state_ff == brb_pkg::ST_RUN) && (issue_left_ff != '0) &&
                      (!rd_pending_ff || move);
   assign ram_wr_en = accept && (req_data.command == brb_pkg::CMD_WRITE) && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brb_pkg::ST_IDLE;
         wp_ff         <= '0;
         rp_ff         <= '0;
         fill_ff       <= '0;
         cap_ff        <= CW'(DEPTH);
         issue_left_ff <= '0;
         emit_idx_ff   <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         fill_ff       <= fill_in;
         cap_ff        <= cap_in;
         issue_left_ff <= issue_left_in;
         emit_idx_ff   <= emit_idx_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_rp_ff   <= run_rp_in;
      run_n_ff    <= run_n_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      fill_in       = fill_ff;
      cap_in        = cap_ff;
      run_rp_in     = run_rp_ff;
      issue_left_in = issue_left_ff;
      emit_idx_in   = emit_idx_ff;
      run_n_in      = run_n_ff;
      rd_pending_in = rd_pending_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.data_out = '0;
               rsp_data_in.has_data = 1'b0;
               rsp_data_in.last     = 1'b1;
               rsp_data_in.granted  = brb_pkg::COUNT_W'(grant);
               case (req_data.command)
                  brb_pkg::CMD_WRITE: begin
                     rsp_data_in.granted = full ? '0 : brb_pkg::COUNT_W'(1);
                     if (!full) begin
                        wp_in   = wp_bump;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  brb_pkg::CMD_ADVANCE: begin
                     rp_in   = rp_adv;
                     fill_in = fill_ff - grant;
                  end
                  brb_pkg::CMD_READ, brb_pkg::CMD_PEEK: begin
                     if (grant != '0) begin
                        // bytes follow from the run sequencer
                        rsp_valid_in  = 1'b0;
                        state_in      = brb_pkg::ST_RUN;
                        run_rp_in     = rp_ff;
                        run_n_in      = RW'(grant);
                        issue_left_in = RW'(grant);
                        emit_idx_in   = '0;
                        rd_pending_in = 1'b0;
                        if (req_data.command == brb_pkg::CMD_READ) begin
                           rp_in   = rp_adv;
                           fill_in = fill_ff - grant;
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
               rsp_data_in.fill_level = brb_pkg::CAP_W'(fill_in);
               rsp_data_in.free_space = brb_pkg::CAP_W'(cap_ff - fill_in);
            end else if (csr_wr_en) begin
               cap_in  = cap_wr;
               wp_in   = '0;
               rp_in   = '0;
               fill_in = '0;
            end
         end
         brb_pkg::ST_RUN: begin
            if (ram_rd_en) begin
               run_rp_in     = run_rp_bump;
               issue_left_in = issue_left_ff - RW'(1);
               rd_pending_in = 1'b1;
            end else if (move) begin
               rd_pending_in = 1'b0;
            end
            if (move) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.data_out   = ram_rd_data;
               rsp_data_in.has_data   = 1'b1;
               rsp_data_in.granted    = brb_pkg::COUNT_W'(run_n_ff);
               rsp_data_in.last       = (emit_idx_ff + RW'(1) == run_n_ff);
               rsp_data_in.fill_level = brb_pkg::CAP_W'(fill_ff);
               rsp_data_in.free_space = brb_pkg::CAP_W'(cap_ff - fill_ff);
               emit_idx_in            = emit_idx_ff + RW'(1);
               if (emit_idx_ff + RW'(1) == run_n_ff) begin
                  state_in = brb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = brb_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   brb_ram #(
      .DEPTH (DEPTH),
      .AW    (PW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_data.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (run_rp_ff),
      .rd_data (ram_rd_data)
   );

   // fill never exceeds the configured capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill above capacity");

   // a fetched byte only waits while a run is in progress
   a_pending_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_pending_ff |-> (state_ff == brb_pkg::ST_RUN))
      else $error("fetched byte outside a run");

   // no new request while a run holds the RAM read port
   a_no_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brb_pkg::ST_RUN) |-> !req_ready)
      else $error("request taken during a run");

   // a result without data is always marked last
   a_nodata_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.has_data) |-> rsp_data_ff.last)
      else $error("data-less result not marked last");

   // bytes of a run leave in order: index advances by one per moved byte
   a_run_progress: assert property (@(posedge clock) disable iff (reset)
      move |=> (emit_idx_ff == $past(emit_idx_ff) + RW'(1)) ||
               (state_ff == brb_pkg::ST_IDLE))
      else $error("run index did not advance");

endmodule
